>>> design/prlc_pkg.sv
// shared types, constants and helpers of the rate-limited pid controller
package prlc_pkg;

  localparam int DW        = 32;           // data width of all fields
  localparam int FRAC      = 16;           // fraction bits, q16.16
  localparam int MUL_STEPS = 32;           // one multiplier bit per cycle
  localparam int DIV_W     = 49;           // dividend width of the serial divider
  localparam int CNT_MW    = $clog2(MUL_STEPS);
  localparam int CNT_DW    = $clog2(DIV_W);

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = -32'sh7fff_ffff - 32'sd1;
  localparam logic signed [31:0] ONE_Q   = 32'sd65536;
  localparam logic [DIV_W-1:0]   ONE_SQ  = 49'h0_0001_0000_0000;

  localparam logic [30:0] MAX_CHANGE_RST = 31'd1638;
  localparam logic [30:0] ZERO_THR_RST   = 31'd3277;

  // register indexes of the configuration port
  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_SETPOINT = 3'd3;
  localparam logic [2:0] REG_MAX_CHG  = 3'd4;
  localparam logic [2:0] REG_ZERO_THR = 3'd5;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [31:0]      den;
  } div_req_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'(SAT_MAX)) r = SAT_MAX;
    else if (v < 52'(SAT_MIN)) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> design/prlc_mul.sv
// bit-serial signed 32x32 multiplier, one partial product per cycle
module prlc_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  prlc_pkg::mul_req_t  req,
  output logic                done,
  output logic signed [63:0]  prod
);

  logic                         busy_r, fix_r, done_r, neg_r;
  logic [prlc_pkg::CNT_MW-1:0]  cnt_r;
  logic [31:0]                  ma_r;
  logic [63:0]                  p_r;
  logic signed [63:0]           prod_r;
  logic [31:0]                  a_mag, b_mag;
  logic [32:0]                  step_sum;

  // operand magnitudes and one shift-add step
  always_comb begin
    a_mag    = req.a[31] ? (~req.a + 32'd1) : req.a;
    b_mag    = req.b[31] ? (~req.b + 32'd1) : req.b;
    step_sum = {1'b0, p_r[63:32]} + (p_r[0] ? {1'b0, ma_r} : 33'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        ma_r   <= a_mag;
        p_r    <= {32'd0, b_mag};
        neg_r  <= req.a[31] ^ req.b[31];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r   <= {step_sum, p_r[31:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == prlc_pkg::CNT_MW'(prlc_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        // apply the sign
        prod_r <= neg_r ? -$signed(p_r) : $signed(p_r);
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

>>> design/prlc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module prlc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  prlc_pkg::div_req_t             req,
  output logic                           done,
  output logic [prlc_pkg::DIV_W-1:0]     quot
);

  logic                          busy_r, done_r;
  logic [prlc_pkg::CNT_DW-1:0]   cnt_r;
  logic [31:0]                   den_r, rem_r;
  logic [prlc_pkg::DIV_W-1:0]    q_r;
  logic [32:0]                   trial, trial_sub;
  logic                          ge;

  // one trial subtraction
  always_comb begin
    trial     = {rem_r, q_r[prlc_pkg::DIV_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den_r  <= req.den;
        rem_r  <= '0;
        q_r    <= req.num;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? trial_sub[31:0] : trial[31:0];
        q_r   <= {q_r[prlc_pkg::DIV_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == prlc_pkg::CNT_DW'(prlc_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> design/pid_rate_limited_controller.sv
// top level: pid step sequencer with slew limit and deadband
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_measured, in_elapsed
//   out     | output    | out_valid/out_stall | out_drive, out_rate_limited, out_zero_forced
//   cfg     | input     | cfg_wr_en           | cfg_index, cfg_data
//
// a beat runs four serial multiplies and two serial divides, one after another
// in the shared units. a zero ki or a zero elapsed skips one divide, both skip both.
// a new beat is taken only once the previous one has left the sequencer.
// reset is synchronous and restores register defaults and the loop state.
// a stalled result sits in the output register while the next beat runs;
// the final step waits for that register to empty.
module pid_rate_limited_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_measured,
  input  logic [30:0]        in_elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic               out_rate_limited,
  output logic               out_zero_forced,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MI, S_MI_W, S_LIM, S_LIM_W, S_DER, S_DER_W,
    S_MP, S_MP_W, S_MK, S_MK_W, S_MD, S_MD_W, S_FIN
  } state_t;

  state_t state_r;

  logic signed [31:0] kp_r, ki_r, kd_r, setpoint_r;
  logic [30:0]        max_chg_r, zero_thr_r;
  logic signed [31:0] meas_r, err_r, integ_r, deriv_r, prev_err_r, prev_drv_r;
  logic [30:0]        dt_r;
  logic signed [32:0] diff_r;
  logic signed [49:0] acc_r;
  logic               lim_last_r;
  logic               out_valid_r, out_lim_r, out_zero_r;
  logic signed [31:0] out_drive_r;

  prlc_pkg::mul_req_t         mul_req;
  prlc_pkg::div_req_t         div_req;
  logic                       mul_done, div_done;
  logic signed [63:0]         mul_prod;
  logic [prlc_pkg::DIV_W-1:0] div_quot;

  logic signed [31:0] err_in, integ_upd, integ_lim, deriv_q, drv_sat, drv_fin;
  logic signed [49:0] term;
  logic signed [48:0] integ_sum;
  logic signed [33:0] lim34, up_b, dn_b, integ34;
  logic [32:0]        diff_mag;
  logic [31:0]        ki_mag, meas_mag;
  logic               clip, forced;

  prlc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .done(mul_done), .prod(mul_prod));
  prlc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quot(div_quot));

  // operand selection for the shared units
  always_comb begin
    diff_mag = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);
    ki_mag   = ki_r[31] ? (~ki_r + 32'd1) : ki_r;
    mul_req  = '0;
    div_req  = '0;
    unique case (state_r)
      S_MI: begin
        mul_req = '{start: 1'b1, a: err_r, b: $signed({1'b0, dt_r})};
      end
      S_MP: begin
        mul_req = '{start: 1'b1, a: kp_r, b: err_r};
      end
      S_MK: begin
        mul_req = '{start: 1'b1, a: ki_r, b: integ_r};
      end
      S_MD: begin
        mul_req = '{start: 1'b1, a: kd_r, b: deriv_r};
      end
      S_LIM: begin
        div_req = '{start: (ki_r != 32'sd0), num: prlc_pkg::ONE_SQ, den: ki_mag};
      end
      S_DER: begin
        div_req = '{start: (dt_r != 31'd0), num: {diff_mag, 16'd0},
                    den: {1'b0, dt_r}};
      end
      default: begin
        mul_req = '0;
        div_req = '0;
      end
    endcase
  end

  // datapath helpers for each step
  always_comb begin
    err_in    = prlc_pkg::sat32(52'(setpoint_r) - 52'(in_measured));
    term      = 50'($signed(mul_prod[63:16]));
    // integral accumulate, held if the last output was rate limited, then clamp to plus or minus one
    integ_sum = lim_last_r ? 49'(integ_r)
                           : (49'(integ_r) + 49'($signed(mul_prod[63:16])));
    if (integ_sum > 49'(prlc_pkg::ONE_Q)) integ_upd = prlc_pkg::ONE_Q;
    else if (integ_sum < -49'(prlc_pkg::ONE_Q)) integ_upd = -prlc_pkg::ONE_Q;
    else integ_upd = integ_sum[31:0];
    // gain based clamp
    lim34   = $signed({1'b0, div_quot[32:0]});
    integ34 = 34'(integ_r);
    if (integ34 > lim34) integ_lim = lim34[31:0];
    else if (integ34 < -lim34) integ_lim = 32'(-lim34);
    else integ_lim = integ_r;
    // signed derivative quotient
    deriv_q = prlc_pkg::sat32(diff_r[32] ? -$signed({3'd0, div_quot})
                                         : $signed({3'd0, div_quot}));
    // slew limit and deadband
    drv_sat = prlc_pkg::sat32(52'(acc_r));
    up_b    = 34'(prev_drv_r) + $signed({3'd0, max_chg_r});
    dn_b    = 34'(prev_drv_r) - $signed({3'd0, max_chg_r});
    clip    = 1'b0;
    drv_fin = drv_sat;
    if (34'(drv_sat) > up_b) begin
      drv_fin = up_b[31:0];
      clip    = 1'b1;
    end else if (34'(drv_sat) < dn_b) begin
      drv_fin = dn_b[31:0];
      clip    = 1'b1;
    end
    meas_mag = meas_r[31] ? (~meas_r + 32'd1) : meas_r;
    forced   = (setpoint_r == 32'sd0) && (meas_mag < {1'b0, zero_thr_r});
  end

  // sequencer, loop state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      setpoint_r  <= '0;
      max_chg_r   <= prlc_pkg::MAX_CHANGE_RST;
      zero_thr_r  <= prlc_pkg::ZERO_THR_RST;
      prev_err_r  <= '0;
      integ_r     <= '0;
      prev_drv_r  <= '0;
      lim_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          prlc_pkg::REG_KP:       kp_r       <= cfg_data;
          prlc_pkg::REG_KI:       ki_r       <= cfg_data;
          prlc_pkg::REG_KD:       kd_r       <= cfg_data;
          prlc_pkg::REG_SETPOINT: setpoint_r <= cfg_data;
          prlc_pkg::REG_MAX_CHG:  max_chg_r  <= cfg_data[30:0];
          prlc_pkg::REG_ZERO_THR: zero_thr_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      // the final step reloads the register itself
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            meas_r  <= in_measured;
            dt_r    <= in_elapsed;
            err_r   <= err_in;
            state_r <= S_MI;
          end
        end
        S_MI: begin
          diff_r     <= 33'(err_r) - 33'(prev_err_r);
          prev_err_r <= err_r;
          state_r    <= S_MI_W;
        end
        S_MI_W: begin
          if (mul_done) begin
            integ_r    <= integ_upd;
            lim_last_r <= 1'b0;
            state_r    <= S_LIM;
          end
        end
        S_LIM: state_r <= (ki_r != 32'sd0) ? S_LIM_W : S_DER;
        S_LIM_W: begin
          if (div_done) begin
            integ_r <= integ_lim;
            state_r <= S_DER;
          end
        end
        S_DER: begin
          if (dt_r != 31'd0) begin
            state_r <= S_DER_W;
          end else begin
            // zero elapsed saturates on the sign of the change
            if (diff_r > 33'sd0) deriv_r <= prlc_pkg::SAT_MAX;
            else if (diff_r < 33'sd0) deriv_r <= prlc_pkg::SAT_MIN;
            else deriv_r <= '0;
            state_r <= S_MP;
          end
        end
        S_DER_W: begin
          if (div_done) begin
            deriv_r <= deriv_q;
            state_r <= S_MP;
          end
        end
        S_MP: state_r <= S_MP_W;
        S_MP_W: begin
          if (mul_done) begin
            acc_r   <= term;
            state_r <= S_MK;
          end
        end
        S_MK: state_r <= S_MK_W;
        S_MK_W: begin
          if (mul_done) begin
            acc_r   <= acc_r + term;
            state_r <= S_MD;
          end
        end
        S_MD: state_r <= S_MD_W;
        S_MD_W: begin
          if (mul_done) begin
            acc_r   <= acc_r + term;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!(out_valid_r && out_stall)) begin
            out_valid_r <= 1'b1;
            out_lim_r   <= clip;
            out_zero_r  <= forced;
            out_drive_r <= forced ? 32'sd0 : drv_fin;
            prev_drv_r  <= forced ? 32'sd0 : drv_fin;
            if (clip) lim_last_r <= 1'b1;
            if (forced) integ_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_drive        = out_drive_r;
  assign out_rate_limited = out_lim_r;
  assign out_zero_forced  = out_zero_r;

endmodule
